/* hdl/gcl_pkg.sv */
// shared types and constants for the glyph cache lookup
package gcl_pkg;

   localparam int unsigned FONT_W  = 8;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned SLOT_W  = 6;

   localparam logic [COUNT_W-1:0] LFU_LIMIT = 16'd30000;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [FONT_W-1:0]  font;
      logic [CHAR_W-1:0]  code;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic load_req;
      logic rd_en;
      logic write;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic last_addr;
      logic rsp_free;
   } sts_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

endpackage

/* hdl/gcl_ctrl.sv */
// controller state machine sequencing request, slot scan, write-back and result
module gcl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  gcl_pkg::sts_type sts,
   output gcl_pkg::cmd_type cmd
);

   gcl_pkg::state_type state_ff;
   gcl_pkg::state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         gcl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = gcl_pkg::ST_SCAN;
            end
         end
         gcl_pkg::ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (sts.last_addr) begin
               state_in = gcl_pkg::ST_DRAIN;
            end
         end
         gcl_pkg::ST_DRAIN: begin
            state_in = gcl_pkg::ST_WRITE;
         end
         gcl_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = gcl_pkg::ST_OUT;
         end
         gcl_pkg::ST_OUT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = gcl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gcl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.rsp_free) else $error("result loaded while output busy");

   a_scan_follows_req: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> cmd.rd_en) else $error("scan did not start after request");

   a_write_once: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> !cmd.write) else $error("write-back repeated");

endmodule

/* hdl/gcl_datapath.sv */
// tag and count memory, scan comparators, lfu tracker, font state and result register
module gcl_datapath #(
   parameter int unsigned CACHE_SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [gcl_pkg::FONT_W-1:0] req_font_id,
   input  logic [gcl_pkg::CHAR_W-1:0] req_char_code,
   input  gcl_pkg::cmd_type           cmd,
   output gcl_pkg::sts_type           sts,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic                       rsp_hit,
   output logic [gcl_pkg::SLOT_W-1:0] rsp_slot,
   output logic                       rsp_reload_font
);

   localparam int unsigned IDX_W = $clog2(CACHE_SLOTS);

   gcl_pkg::entry_type mem [CACHE_SLOTS];
   gcl_pkg::entry_type rd_q_ff;

   logic [CACHE_SLOTS-1:0]      valid_ff;
   logic [gcl_pkg::FONT_W-1:0]  font_ff;
   logic [gcl_pkg::CHAR_W-1:0]  code_ff;
   logic [IDX_W-1:0]            rd_addr_ff;
   logic [IDX_W-1:0]            cmp_idx_ff;
   logic                        cmp_vld_ff;
   logic                        match_found_ff;
   logic [IDX_W-1:0]            match_idx_ff;
   logic [gcl_pkg::COUNT_W-1:0] match_cnt_ff;
   logic [gcl_pkg::COUNT_W-1:0] best_ff;
   logic [IDX_W-1:0]            victim_ff;
   logic [gcl_pkg::FONT_W-1:0]  loaded_font_ff;
   logic                        font_loaded_ff;
   logic                        res_hit_ff;
   logic [gcl_pkg::SLOT_W-1:0]  res_slot_ff;
   logic                        res_reload_ff;
   logic                        rsp_tvalid_ff;
   logic                        rsp_hit_ff;
   logic [gcl_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic                        rsp_reload_ff;

   logic                        entry_valid;
   logic [gcl_pkg::COUNT_W-1:0] entry_count;
   logic                        entry_match;
   logic                        reload;
   logic [IDX_W-1:0]            wr_idx;
   gcl_pkg::entry_type          wr_data;

   // invalid slots read as count zero and never match
   assign entry_valid = valid_ff[cmp_idx_ff];
   assign entry_count = entry_valid ? rd_q_ff.count : '0;
   assign entry_match = entry_valid && (rd_q_ff.font == font_ff) && (rd_q_ff.code == code_ff);
   assign reload      = !font_loaded_ff || (loaded_font_ff != font_ff);

   always_comb begin
      wr_data.font = font_ff;
      wr_data.code = code_ff;
      if (match_found_ff) begin
         wr_idx        = match_idx_ff;
         wr_data.count = (match_cnt_ff == gcl_pkg::COUNT_MAX) ? match_cnt_ff
                                                              : match_cnt_ff + 1'b1;
      end else begin
         wr_idx        = victim_ff;
         wr_data.count = gcl_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[wr_idx] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         font_ff        <= req_font_id;
         code_ff        <= req_char_code;
         rd_addr_ff     <= '0;
         match_found_ff <= 1'b0;
         best_ff        <= gcl_pkg::LFU_LIMIT;
         victim_ff      <= '0;
      end else begin
         if (cmd.rd_en) begin
            rd_addr_ff <= rd_addr_ff + 1'b1;
         end
         if (cmp_vld_ff) begin
            if (entry_match && !match_found_ff) begin
               match_found_ff <= 1'b1;
               match_idx_ff   <= cmp_idx_ff;
               match_cnt_ff   <= entry_count;
            end
            if (entry_count < best_ff) begin
               best_ff   <= entry_count;
               victim_ff <= cmp_idx_ff;
            end
         end
      end
      cmp_idx_ff <= rd_addr_ff;
      if (cmd.write) begin
         res_hit_ff    <= match_found_ff;
         res_slot_ff   <= gcl_pkg::SLOT_W'(wr_idx);
         res_reload_ff <= !match_found_ff && reload;
      end
      if (cmd.load_rsp) begin
         rsp_hit_ff    <= res_hit_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_reload_ff <= res_reload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         cmp_vld_ff     <= 1'b0;
         loaded_font_ff <= '0;
         font_loaded_ff <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.rd_en;
         if (cmd.write && !match_found_ff) begin
            valid_ff[victim_ff] <= 1'b1;
            loaded_font_ff      <= font_ff;
            font_loaded_ff      <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign sts.last_addr  = (rd_addr_ff == IDX_W'(CACHE_SLOTS - 1));
   assign sts.rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_tvalid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_reload_font = rsp_reload_ff;

   a_write_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> !cmp_vld_ff && !cmd.rd_en) else $error("write-back during scan");

   a_best_bounded: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> best_ff <= gcl_pkg::LFU_LIMIT) else $error("lfu tracker above limit");

   a_miss_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.write && !match_found_ff) |=> valid_ff[$past(victim_ff)])
      else $error("refilled slot not marked valid");

   a_font_loaded_after_miss: assert property (@(posedge clock) disable iff (reset)
      (cmd.write && !match_found_ff) |=> font_loaded_ff && (loaded_font_ff == font_ff))
      else $error("loaded font not updated on miss");

endmodule

/* hdl/glyph_cache_lfu_lookup.sv */
// top level of the fully associative glyph cache with lfu replacement
//
//  channel | ports    | direction | tdata bits (low first)
//  --------+----------+-----------+--------------------------------------------
//  request | req_t*   | in        | [7:0] font_id, [15:8] char_code
//  result  | rsp_t*   | out       | [0] hit, [6:1] slot, [7] reload_font
//
//  one request at a time: after the request beat all CACHE_SLOTS slots are scanned, then the drain,
//  write-back and output states follow; the next request is taken once the result is loaded
//  the single read port of the tag/count memory scans one slot per cycle
//  reset clears the per-slot valid flags at once, no clearing pass
//  the result waits in an output register; while it stalls, the next request is
//  scanned and then held, and no further request is taken
module glyph_cache_lfu_lookup #(
   parameter int unsigned CACHE_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // font_id, char_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // hit, slot, reload_font
);

   gcl_pkg::cmd_type           cmd;
   gcl_pkg::sts_type           sts;
   logic                       rsp_hit;
   logic [gcl_pkg::SLOT_W-1:0] rsp_slot;
   logic                       rsp_reload_font;

   gcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gcl_datapath #(
      .CACHE_SLOTS (CACHE_SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_font_id     (req_tdata[7:0]),
      .req_char_code   (req_tdata[15:8]),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_reload_font (rsp_reload_font)
   );

   assign rsp_tdata = {rsp_reload_font, rsp_slot, rsp_hit};

endmodule

/* tb/glyph_cache_lfu_lookup_tb.sv */
// self-checking testbench for the glyph cache lookup with lfu replacement
`timescale 1ns / 1ps

module glyph_cache_lfu_lookup_tb;

   localparam int SLOTS      = 64;
   localparam int SETTLE     = SLOTS + 16;
   localparam int HOLD_BEATS = 400;
   localparam int MAX_REPORT = 10;

   // result beat, lowest bit first: hit, slot, reload_font
   typedef struct packed {
      logic                       reload;
      logic [gcl_pkg::SLOT_W-1:0] slot;
      logic                       hit;
   } lookup_type;

   class lookup_checker_type;
      logic [gcl_pkg::CHAR_W-1:0]  tag_char [SLOTS];
      logic [gcl_pkg::FONT_W-1:0]  tag_font [SLOTS];
      logic [gcl_pkg::COUNT_W-1:0] use_count [SLOTS];
      bit                          slot_valid [SLOTS];
      logic [gcl_pkg::FONT_W-1:0]  cur_font;
      bit                          font_loaded;
      lookup_type                  expected_lookups [$];
      int                          errors;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            tag_char[i]   = '0;
            tag_font[i]   = '0;
            use_count[i]  = '0;
            slot_valid[i] = 1'b0;
         end
         cur_font    = '0;
         font_loaded = 1'b0;
         errors      = 0;
      endfunction

      function void note_lookup(input logic [gcl_pkg::FONT_W-1:0] font,
                                input logic [gcl_pkg::CHAR_W-1:0] code);
         lookup_type  res;
         bit          found;
         int          victim;
         int unsigned best;
         res   = '0;
         found = 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_valid[i] && tag_char[i] == code && tag_font[i] == font) begin
               found = 1'b1;
               if (use_count[i] != gcl_pkg::COUNT_MAX)
                  use_count[i] = use_count[i] + 1'b1;
               res.hit  = 1'b1;
               res.slot = gcl_pkg::SLOT_W'(i);
            end
         end
         if (!found) begin
            if (!font_loaded || cur_font != font) begin
               res.reload  = 1'b1;
               cur_font    = font;
               font_loaded = 1'b1;
            end
            victim = 0;
            best   = 32'(gcl_pkg::LFU_LIMIT);
            for (int i = 0; i < SLOTS; i++) begin
               if (32'(use_count[i]) < best) begin
                  best   = 32'(use_count[i]);
                  victim = i;
               end
            end
            tag_char[victim]   = code;
            tag_font[victim]   = font;
            use_count[victim]  = gcl_pkg::COUNT_W'(1);
            slot_valid[victim] = 1'b1;
            res.slot           = gcl_pkg::SLOT_W'(victim);
         end
         expected_lookups.push_back(res);
      endfunction

      function void check_lookup(input logic [7:0] data);
         lookup_type got;
         lookup_type want;
         got = data;
         if (expected_lookups.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORT)
               $display("%0t: result beat %h with no lookup pending", $time, data);
            return;
         end
         want = expected_lookups.pop_front();
         if (got.hit !== want.hit || got.slot !== want.slot || got.reload !== want.reload) begin
            errors++;
            if (errors <= MAX_REPORT)
               $display("%0t: expected hit %b slot %0d reload %b, got hit %b slot %0d reload %b",
                        $time, want.hit, want.slot, want.reload, got.hit, got.slot, got.reload);
         end
      endfunction

      function int pending();
         return expected_lookups.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // font_id, char_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // hit, slot, reload_font

   lookup_checker_type board;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   logic               hold_rsp = 1'b0;
   event               start_hold;

   glyph_cache_lfu_lookup #(
      .CACHE_SLOTS(SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // long receiver hold-off
   initial begin
      forever begin
         @(start_hold);
         hold_rsp <= 1'b1;
         repeat (HOLD_BEATS) @(posedge clock);
         hold_rsp <= 1'b0;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_lookup(rsp_tdata);
         rsp_tready <= !reset && !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_glyph(input logic [15:0] beat);
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_lookup(beat[7:0], beat[15:8]);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic drain_lookups();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_glyph();
      int r;
      r = $urandom_range(99);
      if (r < 15)
         return 16'($urandom);
      else if (r < 50)
         return {8'($urandom_range(7)), 8'($urandom_range(3))};
      else
         return {8'($urandom_range(47)), 8'($urandom_range(3))};
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++)
         send_glyph(pick_glyph());
   endtask

   initial begin
      #36_000_000;
      $display("glyph_cache_lfu_lookup_tb failed");
      $finish;
   end

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tdata is {char_code, font_id}
      send_glyph({8'h00, 8'h00});
      send_glyph({8'h00, 8'h00});
      send_glyph({8'h00, 8'h00});
      send_glyph({8'hFF, 8'h00});
      send_glyph({8'hFF, 8'hFF});
      send_glyph({8'h00, 8'hFF});
      send_glyph({8'hFF, 8'h00});
      send_glyph({8'hFF, 8'hFF});
      send_glyph({8'hAA, 8'h55});
      send_glyph({8'h55, 8'hAA});
      send_glyph({8'hAA, 8'h55});
      send_glyph({8'h55, 8'h55});
      send_glyph({8'h00, 8'h01});
      send_glyph({8'h01, 8'h00});
      send_glyph({8'h00, 8'h00});
      send_glyph({8'h80, 8'h80});
      send_glyph({8'h7F, 8'h7F});
      send_glyph({8'h80, 8'h80});
      send_glyph({8'h01, 8'h00});
      send_glyph({8'h55, 8'hAA});
      drain_lookups();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               ->start_hold;
            end
            1: begin
               send_idle_pct  = 65;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 65;
            end
            default: begin
               send_idle_pct  = 6;
               recv_stall_pct = 6;
            end
         endcase
         run_random(333);
         drain_lookups();
      end

      if (board.errors == 0 && board.pending() == 0)
         $display("glyph_cache_lfu_lookup_tb passed");
      else
         $display("glyph_cache_lfu_lookup_tb failed");
      $finish;
   end

endmodule
